// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// edge of clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every edge.
`define CHK_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the cause holds, the effect must hold in the same cycle.
`define CHK_SAME(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
    else $error(msg);

// When the cause holds, the effect must hold in the next cycle.
`define CHK_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error(msg);

`endif

// ----- hdl/jsme_pkg.sv -----
package jsme_pkg;

  // Input beat: one scan request or one received reply word.
  typedef struct packed {
    logic        mode;
    logic [3:0]  prolog_bits;
    logic [10:0] prolog_value;
    logic [5:0]  data_bits;
    logic [63:0] data_value;
    logic        capture;
  } in_t;

  // Output beat: one command byte or one corrected reply word.
  typedef struct packed {
    logic        result_kind;
    logic [7:0]  command_byte;
    logic [63:0] corrected_word;
    logic [3:0]  reply_bytes;
    logic        last;
    logic        too_long;
  } out_t;

  // Command opcode bits.
  localparam logic [7:0] OP_NEGW = 8'h01;
  localparam logic [7:0] OP_BITS = 8'h02;
  localparam logic [7:0] OP_LSBF = 8'h08;
  localparam logic [7:0] OP_TDI  = 8'h10;
  localparam logic [7:0] OP_TDO  = 8'h20;
  localparam logic [7:0] OP_TMS  = 8'h40;
  localparam logic [7:0] TMS_CMD = OP_TMS | OP_BITS | OP_NEGW | OP_LSBF;

  // Limits of a scan request.
  localparam logic [3:0] MAX_PROLOG_BITS = 4'd11;
  localparam logic [5:0] MAX_DATA_BITS   = 6'd57;

  localparam int PROG_LEN = 20;

  // Byte source of a microcode step.
  typedef enum logic [4:0] {
    SRC_NONE       = 5'd0,
    SRC_TMS_CMD    = 5'd1,
    SRC_PCNT_SHORT = 5'd2,
    SRC_PVAL_LO8   = 5'd3,
    SRC_SIX        = 5'd4,
    SRC_PVAL_LO7   = 5'd5,
    SRC_PCNT_LONG  = 5'd6,
    SRC_PVAL_HI    = 5'd7,
    SRC_WHOLE_CMD  = 5'd8,
    SRC_WHOLE_CNT  = 5'd9,
    SRC_ZERO       = 5'd10,
    SRC_DATA       = 5'd11,
    SRC_PART_CMD   = 5'd12,
    SRC_PART_CNT   = 5'd13,
    SRC_TAIL       = 5'd14,
    SRC_FINAL_CMD  = 5'd15,
    SRC_ONE        = 5'd16,
    SRC_FINAL_BYTE = 5'd17
  } src_t;

  // Jump condition of a microcode step.
  typedef enum logic [2:0] {
    J_NEVER   = 3'd0,
    J_ALWAYS  = 3'd1,
    J_LONG    = 3'd2,
    J_NOWHOLE = 3'd3,
    J_MORE    = 3'd4,
    J_NOPART  = 3'd5
  } jcond_t;

  // Condition under which the emitted byte closes the request.
  typedef enum logic [1:0] {
    L_NEVER  = 2'd0,
    L_NODATA = 2'd1,
    L_ALWAYS = 2'd2
  } lcond_t;

  typedef struct packed {
    src_t       src;
    jcond_t     jc;
    logic [4:0] target;
    lcond_t     lc;
  } ctrl_t;

  // Microcode program for one scan request.
  function automatic ctrl_t ctrl_rom(input logic [4:0] pc);
    ctrl_t w;
    w = '{src: SRC_NONE, jc: J_NEVER, target: 5'd0, lc: L_NEVER};
    case (pc)
      // TMS prolog, short form or split into two commands.
      5'd0:  w = '{src: SRC_TMS_CMD,    jc: J_LONG,    target: 5'd3,  lc: L_NEVER};
      5'd1:  w = '{src: SRC_PCNT_SHORT, jc: J_NEVER,   target: 5'd0,  lc: L_NEVER};
      5'd2:  w = '{src: SRC_PVAL_LO8,   jc: J_ALWAYS,  target: 5'd8,  lc: L_NODATA};
      5'd3:  w = '{src: SRC_SIX,        jc: J_NEVER,   target: 5'd0,  lc: L_NEVER};
      5'd4:  w = '{src: SRC_PVAL_LO7,   jc: J_NEVER,   target: 5'd0,  lc: L_NEVER};
      5'd5:  w = '{src: SRC_TMS_CMD,    jc: J_NEVER,   target: 5'd0,  lc: L_NEVER};
      5'd6:  w = '{src: SRC_PCNT_LONG,  jc: J_NEVER,   target: 5'd0,  lc: L_NEVER};
      5'd7:  w = '{src: SRC_PVAL_HI,    jc: J_NEVER,   target: 5'd0,  lc: L_NODATA};
      // Whole data bytes.
      5'd8:  w = '{src: SRC_NONE,       jc: J_NOWHOLE, target: 5'd13, lc: L_NEVER};
      5'd9:  w = '{src: SRC_WHOLE_CMD,  jc: J_NEVER,   target: 5'd0,  lc: L_NEVER};
      5'd10: w = '{src: SRC_WHOLE_CNT,  jc: J_NEVER,   target: 5'd0,  lc: L_NEVER};
      5'd11: w = '{src: SRC_ZERO,       jc: J_NEVER,   target: 5'd0,  lc: L_NEVER};
      5'd12: w = '{src: SRC_DATA,       jc: J_MORE,    target: 5'd12, lc: L_NEVER};
      // Partial data bits.
      5'd13: w = '{src: SRC_NONE,       jc: J_NOPART,  target: 5'd17, lc: L_NEVER};
      5'd14: w = '{src: SRC_PART_CMD,   jc: J_NEVER,   target: 5'd0,  lc: L_NEVER};
      5'd15: w = '{src: SRC_PART_CNT,   jc: J_NEVER,   target: 5'd0,  lc: L_NEVER};
      5'd16: w = '{src: SRC_TAIL,       jc: J_NEVER,   target: 5'd0,  lc: L_NEVER};
      // Final data bit with TMS high.
      5'd17: w = '{src: SRC_FINAL_CMD,  jc: J_NEVER,   target: 5'd0,  lc: L_NEVER};
      5'd18: w = '{src: SRC_ONE,        jc: J_NEVER,   target: 5'd0,  lc: L_NEVER};
      5'd19: w = '{src: SRC_FINAL_BYTE, jc: J_NEVER,   target: 5'd0,  lc: L_ALWAYS};
      default: w = '{src: SRC_NONE, jc: J_NEVER, target: 5'd0, lc: L_NEVER};
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/jtag_scan_to_mpsse_encoder_top.sv -----
// Turns JTAG scan requests into MPSSE command bytes and realigns received
// reply words. A scan request is taken in one beat and then played out by a
// 20-step microcode program that emits one command byte per cycle as long as
// the output side keeps taking beats; its two pure branch steps emit no byte.
// A request yields at most 21 bytes, and no new beat is taken until it ends.
// A reply word in fix mode, an out-of-range request and an empty request are
// handled in the accepting cycle itself, and the next beat can be taken in the
// cycle after once any result beat has been taken by the output side.
// Capturing scans record the masks that a later fix-mode beat applies.
`include "assert_macros.svh"

module jtag_scan_to_mpsse_encoder_top import jsme_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Sequencer control.
  logic       busy_r, busy_nxt;
  logic [4:0] pc_r, pc_nxt;
  ctrl_t      ctrl;
  logic       step_go, jump_now, last_now;
  logic [7:0] byte_now;

  // Latched request.
  logic [3:0]  pbits_r;
  logic [14:0] pval_r;
  logic        has_data_r;
  logic [2:0]  whole_r, part_r, cnt_r;
  logic        cap_r, final_bit_r;
  logic [63:0] t_r;
  logic [3:0]  reply_r;

  // Capture masks.
  logic [2:0]  pbc_r;
  logic [63:0] tbm_r, pbm_r, top_r;

  // Output register.
  logic out_valid_r;
  out_t out_data_r;
  logic out_free;

  // Accept-time decode.
  logic        accept, too_long, empty;
  logic        in_has_data;
  logic [5:0]  dm1;
  logic [2:0]  in_whole, in_part;
  logic [3:0]  wbc;
  logic [3:0]  pbits_ext;
  logic [14:0] pval_ext;
  logic [63:0] dval_m;
  logic [10:0] pval_m;

  // Fix-mode datapath.
  logic [63:0] fw_in, fw_hb, fw_mid, fw_out;
  logic        fw_fhb;
  logic [3:0]  fw_sh;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = !busy_r && out_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Decode of the incoming request.
  always_comb begin
    too_long    = (in_data.prolog_bits > MAX_PROLOG_BITS) || (in_data.data_bits > MAX_DATA_BITS);
    in_has_data = in_data.data_bits != 6'd0;
    empty       = (in_data.prolog_bits == 4'd0) && !in_has_data;
    dm1         = in_data.data_bits - 6'd1;
    in_whole    = dm1[5:3];
    in_part     = dm1[2:0];
    wbc         = {1'b0, in_whole} + {3'b0, (in_part != 3'd0)};
    pval_m      = in_data.prolog_value & ~(~11'd0 << in_data.prolog_bits);
    dval_m      = in_data.data_value & ~(~64'd0 << in_data.data_bits);
    pbits_ext   = in_data.prolog_bits + (in_has_data ? 4'd3 : 4'd0);
    pval_ext    = {4'b0, pval_m} | (in_has_data ? (15'd1 << in_data.prolog_bits) : 15'd0);
  end

  // Realignment of a received word with the stored masks.
  always_comb begin
    fw_in  = in_data.data_value;
    fw_fhb = (fw_in & tbm_r) != 64'd0;
    fw_sh  = 4'd8 - {1'b0, pbc_r};
    fw_hb  = pbm_r & ((fw_in & pbm_r) >> fw_sh);
    fw_mid = (pbc_r != 3'd0) ? ((fw_in & ~pbm_r) | fw_hb) : fw_in;
    fw_out = fw_mid & (top_r - 64'd1);
    if (fw_fhb) begin
      fw_out = fw_out | top_r;
    end
  end

  // Current microcode step and the byte it selects.
  always_comb begin
    ctrl = ctrl_rom(pc_r);
    case (ctrl.src)
      SRC_TMS_CMD:    byte_now = TMS_CMD;
      SRC_PCNT_SHORT: byte_now = {4'b0, pbits_r - 4'd1};
      SRC_PVAL_LO8:   byte_now = pval_r[7:0];
      SRC_SIX:        byte_now = 8'd6;
      SRC_PVAL_LO7:   byte_now = {1'b0, pval_r[6:0]};
      SRC_PCNT_LONG:  byte_now = {4'b0, pbits_r - 4'd8};
      SRC_PVAL_HI:    byte_now = pval_r[14:7];
      SRC_WHOLE_CMD:  byte_now = OP_TDI | OP_NEGW | OP_LSBF | (cap_r ? OP_TDO : 8'd0);
      SRC_WHOLE_CNT:  byte_now = {5'b0, whole_r - 3'd1};
      SRC_ZERO:       byte_now = 8'd0;
      SRC_DATA:       byte_now = t_r[7:0];
      SRC_PART_CMD:   byte_now = OP_TDI | OP_BITS | OP_NEGW | OP_LSBF | (cap_r ? OP_TDO : 8'd0);
      SRC_PART_CNT:   byte_now = {5'b0, part_r - 3'd1};
      SRC_TAIL:       byte_now = t_r[7:0];
      SRC_FINAL_CMD:  byte_now = TMS_CMD | (cap_r ? OP_TDO : 8'd0);
      SRC_ONE:        byte_now = 8'd1;
      SRC_FINAL_BYTE: byte_now = {final_bit_r, 7'b0} | 8'h03;
      default:        byte_now = 8'd0;
    endcase

    case (ctrl.jc)
      J_ALWAYS:  jump_now = 1'b1;
      J_LONG:    jump_now = pbits_r >= 4'd8;
      J_NOWHOLE: jump_now = whole_r == 3'd0;
      J_MORE:    jump_now = cnt_r != 3'd1;
      J_NOPART:  jump_now = part_r == 3'd0;
      default:   jump_now = 1'b0;
    endcase

    case (ctrl.lc)
      L_NODATA: last_now = !has_data_r;
      L_ALWAYS: last_now = 1'b1;
      default:  last_now = 1'b0;
    endcase

    step_go = busy_r && ((ctrl.src == SRC_NONE) || out_free);
  end

  // Sequencer next state.
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (accept) begin
      busy_nxt = !in_data.mode && !too_long && !empty;
      pc_nxt   = 5'd0;
    end else if (step_go) begin
      if ((ctrl.src != SRC_NONE) && last_now) begin
        busy_nxt = 1'b0;
      end
      pc_nxt = jump_now ? ctrl.target : pc_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  // Request latch and data shifter.
  always_ff @(posedge clk) begin
    if (accept) begin
      pbits_r     <= pbits_ext;
      pval_r      <= pval_ext;
      has_data_r  <= in_has_data;
      whole_r     <= in_whole;
      part_r      <= in_part;
      cnt_r       <= in_whole;
      cap_r       <= in_data.capture;
      final_bit_r <= in_data.data_value[dm1];
      t_r         <= dval_m;
      reply_r     <= (in_data.capture && in_has_data) ? wbc + 4'd1 : 4'd0;
    end else if (step_go && (ctrl.src == SRC_DATA)) begin
      t_r   <= {8'd0, t_r[63:8]};
      cnt_r <= cnt_r - 3'd1;
    end
  end

  // Capture masks, updated only by a capturing scan that carries data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pbc_r <= 3'd0;
      tbm_r <= 64'd0;
      pbm_r <= 64'd0;
      top_r <= 64'd0;
    end else if (accept && !in_data.mode && !too_long && in_has_data && in_data.capture) begin
      pbc_r <= in_part;
      pbm_r <= (in_part != 3'd0) ? (64'hff << {in_whole, 3'b0}) : 64'd0;
      tbm_r <= 64'h40 << {wbc, 3'b0};
      top_r <= 64'd1 << dm1;
    end
  end

  // Output register: fix-mode and rejected beats load at acceptance,
  // command bytes load as the sequencer emits them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && (in_data.mode || too_long)) begin
      out_valid_r <= 1'b1;
    end else if (step_go && (ctrl.src != SRC_NONE)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.mode) begin
      out_data_r <= '{result_kind: 1'b1, command_byte: 8'd0, corrected_word: fw_out,
                      reply_bytes: 4'd0, last: 1'b1, too_long: 1'b0};
    end else if (accept && too_long) begin
      out_data_r <= '{result_kind: 1'b0, command_byte: 8'd0, corrected_word: 64'd0,
                      reply_bytes: 4'd0, last: 1'b1, too_long: 1'b1};
    end else if (step_go && (ctrl.src != SRC_NONE)) begin
      out_data_r <= '{result_kind: 1'b0, command_byte: byte_now, corrected_word: 64'd0,
                      reply_bytes: last_now ? reply_r : 4'd0, last: last_now,
                      too_long: 1'b0};
    end
  end

  // Checks on the sequencer.
  `CHK_SAME(a_no_accept_busy, busy_r, !in_ready, "beat accepted while a scan is running")
  `CHK_ALWAYS(a_pc_range, !busy_r || (pc_r < 5'(PROG_LEN)), "step counter outside the program")
  `CHK_NEXT(a_last_ends, step_go && (ctrl.src != SRC_NONE) && last_now, !busy_r,
    "sequencer still running after the closing byte")
  `CHK_SAME(a_byte_count, busy_r && (ctrl.src == SRC_DATA), cnt_r != 3'd0,
    "data byte emitted with no bytes left")

endmodule
